// ===== src/indexed_sequence_store_macros.svh =====
// Assertion macros used by the isq_ctrl module of the indexed sequence store RTL.
`ifndef INDEXED_SEQUENCE_STORE_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge, masked while reset is active.
`define ISQ_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ISQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ISQ_ASSERT(label, clk, rstn, prop, msg)

`define ISQ_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== src/isq_pkg.sv =====
// Shared types and constants of the indexed sequence store.
package isq_pkg;

  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 16;

  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned POS_W       = 11;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned READ_W      = 16;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_READ   = 3'd0,
    OP_INSERT = 3'd1,
    OP_HEAD   = 3'd2,
    OP_TAIL   = 3'd3,
    OP_DELETE = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic ins;         // open a gap at pos, write the new value there
    logic del;         // close the gap at pos
    logic lane_load;   // copy the stored row into the read lane
    logic lane_shift;  // move the read lane one cell toward the head
  } cell_ctl_t;

endpackage

// ===== src/indexed_sequence_store.sv =====
// Top level of the indexed sequence store: controller and shifting cell row.
//
//  channel  | dir | tdata fields (low bit first)
//  ---------+-----+----------------------------------------------------------
//  s_axis   | in  | opcode[2:0], position[13:3], value[29:14], zero[31:30]
//  m_axis   | out | status[1:0], read_value[17:2], count[28:18], zero[31:29]
//
//  Insert, delete and rejected beats: the result is valid in the cycle after acceptance.
//  Read at position p: the read lane is loaded from the row, then steps one cell a cycle toward the head.
//  One beat in flight; s_axis_tready drops during a read walk or while a result stalls.
//  Reset clears the entry count and the handshake state; cell contents are not cleared.
module indexed_sequence_store #(
  parameter int unsigned CAPACITY   = isq_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = isq_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // opcode[2:0], position[13:3], value[29:14], zero pad[31:30]
  input  logic [isq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], read_value[17:2], count[28:18], zero pad[31:29]
  output logic [isq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import isq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned OutUsed = STATUS_W + READ_W + COUNT_W;

  logic [OPCODE_W-1:0]   opcode;
  logic [POS_W-1:0]      position;
  logic [VALUE_W-1:0]    value;
  logic [STATUS_W-1:0]   status;
  logic [READ_W-1:0]     read_value;
  logic [COUNT_W-1:0]    count;
  cell_ctl_t             cell_ctl;
  logic [PW-1:0]         cell_pos;
  logic [DATA_WIDTH-1:0] cell_wr;

  logic [DATA_WIDTH-1:0] data_w [CAPACITY];
  logic [DATA_WIDTH-1:0] lane_w [CAPACITY];

  assign opcode   = s_axis_tdata[OPCODE_W-1:0];
  assign position = s_axis_tdata[OPCODE_W +: POS_W];
  assign value    = s_axis_tdata[OPCODE_W+POS_W +: VALUE_W];

  assign m_axis_tdata = {{(OUT_TDATA_W-OutUsed){1'b0}}, count, read_value, status};

  isq_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .CW         (CW),
    .PW         (PW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .opcode_i     (opcode),
    .position_i   (position),
    .value_i      (value),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .status_o     (status),
    .read_value_o (read_value),
    .count_o      (count),
    .cell_ctl_o   (cell_ctl),
    .cell_pos_o   (cell_pos),
    .cell_wr_o    (cell_wr),
    .lane_head_i  (lane_w[0])
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data;
    logic [DATA_WIDTH-1:0] next_data;
    logic [DATA_WIDTH-1:0] next_lane;

    if (i == 0) begin : g_head
      assign prev_data = '0;
    end else begin : g_body
      assign prev_data = data_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_data = '0;
      assign next_lane = '0;
    end else begin : g_link
      assign next_data = data_w[i+1];
      assign next_lane = lane_w[i+1];
    end

    isq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW),
      .IDX        (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .pos_i       (cell_pos),
      .wr_data_i   (cell_wr),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .next_lane_i (next_lane),
      .data_o      (data_w[i]),
      .lane_o      (lane_w[i])
    );
  end

endmodule

// ===== src/isq_cell.sv =====
// One storage cell of the shifting row, with its read lane stage.
module isq_cell #(
  parameter int unsigned DATA_WIDTH = isq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned PW         = isq_pkg::POS_W,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  isq_pkg::cell_ctl_t    ctl_i,
  input  logic [PW-1:0]         pos_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  input  logic [DATA_WIDTH-1:0] prev_data_i,
  input  logic [DATA_WIDTH-1:0] next_data_i,
  input  logic [DATA_WIDTH-1:0] next_lane_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] lane_o
);
  import isq_pkg::*;

  localparam logic [PW-1:0] MyIdx = PW'(IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] lane_q, lane_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (MyIdx > pos_i) begin
        data_d = prev_data_i;
      end else if (MyIdx == pos_i) begin
        data_d = wr_data_i;
      end
    end else if (ctl_i.del) begin
      if (MyIdx >= pos_i) begin
        data_d = next_data_i;
      end
    end
  end

  always_comb begin
    lane_d = lane_q;
    if (ctl_i.lane_load) begin
      lane_d = data_q;
    end else if (ctl_i.lane_shift) begin
      lane_d = next_lane_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    lane_q <= lane_d;
  end

  assign data_o = data_q;
  assign lane_o = lane_q;

endmodule

// ===== src/isq_ctrl.sv =====
// Opcode decode, entry count, read walk and result register of the store.
`include "indexed_sequence_store_macros.svh"

module isq_ctrl #(
  parameter int unsigned CAPACITY   = isq_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = isq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned CW         = $clog2(CAPACITY + 1),
  parameter int unsigned PW         = (CW > isq_pkg::POS_W) ? CW : isq_pkg::POS_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [isq_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [isq_pkg::POS_W-1:0]      position_i,
  input  logic [isq_pkg::VALUE_W-1:0]    value_i,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [isq_pkg::STATUS_W-1:0]   status_o,
  output logic [isq_pkg::READ_W-1:0]     read_value_o,
  output logic [isq_pkg::COUNT_W-1:0]    count_o,
  output isq_pkg::cell_ctl_t             cell_ctl_o,
  output logic [PW-1:0]                  cell_pos_o,
  output logic [DATA_WIDTH-1:0]          cell_wr_o,
  input  logic [DATA_WIDTH-1:0]          lane_head_i
);
  import isq_pkg::*;

  localparam logic [CW-1:0] CapVal = CW'(CAPACITY);

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [PW-1:0]         rem_q, rem_d;
  logic                  m_valid_q, m_valid_d;
  logic [STATUS_W-1:0]   m_status_q;
  logic [READ_W-1:0]     m_read_q;
  logic [COUNT_W-1:0]    m_count_q;

  logic                  in_acc;
  logic                  out_load;
  status_e               res_status;
  logic [READ_W-1:0]     res_read;
  logic [PW-1:0]         pos_ext;
  logic [PW-1:0]         count_ext;
  logic [PW-1:0]         ins_pos;
  cell_ctl_t             ctl;
  logic [DATA_WIDTH+VALUE_W-1:0] wr_ext;
  logic [DATA_WIDTH+READ_W-1:0]  rd_ext;
  logic [CW+COUNT_W-1:0]         cnt_ext;

  assign s_ready_o = (state_q == S_IDLE) && (!m_valid_q || m_ready_i);
  assign in_acc    = s_valid_i && s_ready_o;
  assign pos_ext   = PW'(position_i);
  assign count_ext = PW'(count_q);

  assign wr_ext    = {{DATA_WIDTH{1'b0}}, value_i};
  assign cell_wr_o = wr_ext[DATA_WIDTH-1:0];
  assign rd_ext    = {{READ_W{1'b0}}, lane_head_i};

  always_comb begin
    case (opcode_i)
      OP_HEAD: ins_pos = '0;
      OP_TAIL: ins_pos = count_ext;
      default: ins_pos = pos_ext;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rem_d      = rem_q;
    ctl        = '0;
    out_load   = 1'b0;
    res_status = ST_RANGE;
    res_read   = '0;
    cell_pos_o = pos_ext;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          case (opcode_i)
            OP_READ: begin
              if (pos_ext < count_ext) begin
                // walk the read lane down to the head
                ctl.lane_load = 1'b1;
                rem_d         = pos_ext;
                state_d       = S_READ;
                out_load      = 1'b0;
              end
            end
            OP_INSERT, OP_HEAD, OP_TAIL: begin
              cell_pos_o = ins_pos;
              if (ins_pos > count_ext) begin
                res_status = ST_RANGE;
              end else if (count_q == CapVal) begin
                res_status = ST_FULL;
              end else begin
                ctl.ins    = 1'b1;
                count_d    = count_q + 1'b1;
                res_status = ST_DONE;
              end
            end
            OP_DELETE: begin
              if (pos_ext < count_ext) begin
                ctl.del    = 1'b1;
                count_d    = count_q - 1'b1;
                res_status = ST_DONE;
              end
            end
            default: res_status = ST_RANGE;
          endcase
        end
      end
      S_READ: begin
        if (rem_q == '0) begin
          out_load   = 1'b1;
          res_status = ST_DONE;
          res_read   = rd_ext[READ_W-1:0];
          state_d    = S_IDLE;
        end else begin
          ctl.lane_shift = 1'b1;
          rem_d          = rem_q - 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cell_ctl_o = ctl;
  assign cnt_ext    = {{COUNT_W{1'b0}}, count_d};

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rem_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rem_q     <= rem_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_status_q <= res_status;
      m_read_q   <= res_read;
      m_count_q  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign m_valid_o    = m_valid_q;
  assign status_o     = m_status_q;
  assign read_value_o = m_read_q;
  assign count_o      = m_count_q;

  `ISQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CapVal, "entry count above capacity")
  `ISQ_ASSERT(a_read_no_result, clk_i, rst_ni, (state_q == S_READ) |-> !m_valid_q, "result pending during read walk")
  `ISQ_ASSERT(a_count_hold, clk_i, rst_ni, !in_acc |=> $stable(count_q), "count moved without an accepted beat")
  `ISQ_ASSERT(a_count_step, clk_i, rst_ni, in_acc |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1), "count moved by more than one")

endmodule

// ===== bench/indexed_sequence_store_tb.sv =====
// Self-checking testbench for the indexed sequence store stream block.
`timescale 1ns / 100ps

module indexed_sequence_store_tb;
  import isq_pkg::*;

  localparam int unsigned CAPACITY     = CAPACITY_DEF;
  localparam int unsigned POS_MAX      = (1 << POS_W) - 1;
  localparam int unsigned VALUE_MAX    = (1 << VALUE_W) - 1;
  localparam int unsigned MAX_WAIT     = 10;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned TAIL_CYCLES  = CAPACITY + 8;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned NOISE_PCT    = 4;

  localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;

  // Operation mixes of the random phases.
  localparam int MIX_EVEN   = 0;
  localparam int MIX_GROW   = 1;
  localparam int MIX_SHRINK = 2;

  typedef struct {
    status_e              status;
    logic [READ_W-1:0]    rd;
    logic [COUNT_W-1:0]   count;
  } reply_t;

  // Shadow copy of the cell row plus the queue of replies still owed.
  class store_shadow;
    logic [VALUE_W-1:0] cells [CAPACITY];
    int unsigned        n_entries;
    reply_t             pending_replies [$];
    int unsigned        n_errors;
    int unsigned        n_ops;
    int unsigned        n_replies;
    int unsigned        n_full;
    int unsigned        n_range;
    int unsigned        peak;

    function new();
      n_entries = 0;
      n_errors  = 0;
      n_ops     = 0;
      n_replies = 0;
      n_full    = 0;
      n_range   = 0;
      peak      = 0;
    endfunction

    function status_e insert_at(int unsigned pos, logic [VALUE_W-1:0] val);
      if (pos > n_entries) return ST_RANGE;
      if (n_entries >= CAPACITY) return ST_FULL;
      for (int unsigned i = n_entries; i > pos; i--) cells[i] = cells[i-1];
      cells[pos] = val;
      n_entries++;
      return ST_DONE;
    endfunction

    function void note_op(logic [IN_TDATA_W-1:0] beat);
      logic [OPCODE_W-1:0] op;
      int unsigned         pos;
      logic [VALUE_W-1:0]  val;
      reply_t              exp;
      op         = beat[OPCODE_W-1:0];
      pos        = 32'(beat[OPCODE_W +: POS_W]);
      val        = beat[OPCODE_W+POS_W +: VALUE_W];
      exp.status = ST_RANGE;
      exp.rd     = '0;
      case (op)
        OP_READ: begin
          if (pos < n_entries) begin
            exp.rd     = cells[pos];
            exp.status = ST_DONE;
          end
        end
        OP_INSERT: exp.status = insert_at(pos, val);
        OP_HEAD:   exp.status = insert_at(0, val);
        OP_TAIL:   exp.status = insert_at(n_entries, val);
        OP_DELETE: begin
          if (pos < n_entries) begin
            for (int unsigned i = pos; i + 1 < n_entries; i++) cells[i] = cells[i+1];
            n_entries--;
            exp.status = ST_DONE;
          end
        end
        default: ;
      endcase
      exp.count = COUNT_W'(n_entries);
      if (exp.status == ST_FULL) n_full++;
      if (exp.status == ST_RANGE) n_range++;
      if (n_entries > peak) peak = n_entries;
      n_ops++;
      pending_replies.push_back(exp);
    endfunction

    function void check_reply(logic [OUT_TDATA_W-1:0] beat);
      reply_t exp;
      if (pending_replies.size() == 0) begin
        $error("reply beat 0x%08h with no operation pending", beat);
        n_errors++;
        return;
      end
      exp = pending_replies.pop_front();
      n_replies++;
      if (beat[STATUS_W-1:0] !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, beat[STATUS_W-1:0]);
        n_errors++;
      end
      if (beat[STATUS_W +: READ_W] !== exp.rd) begin
        $error("read_value: expected 0x%04h, actual 0x%04h", exp.rd, beat[STATUS_W +: READ_W]);
        n_errors++;
      end
      if (beat[STATUS_W+READ_W +: COUNT_W] !== exp.count) begin
        $error("count: expected %0d, actual %0d", exp.count, beat[STATUS_W+READ_W +: COUNT_W]);
        n_errors++;
      end
      if (beat[OUT_TDATA_W-1:STATUS_W+READ_W+COUNT_W] !== '0) begin
        $error("pad: expected 0, actual 0x%0h", beat[OUT_TDATA_W-1:STATUS_W+READ_W+COUNT_W]);
        n_errors++;
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  bit          quiet_tx  = 1'b0;
  bit          quiet_rx  = 1'b0;
  int unsigned cycle_cnt = 0;

  store_shadow shadow = new();

  indexed_sequence_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Check replies before noting a new operation: a reply never belongs to a
  // beat accepted on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) shadow.check_reply(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) shadow.note_op(s_axis_tdata);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result side: stall a random number of cycles ahead of every beat.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = quiet_rx ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
      if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_op(input logic [OPCODE_W-1:0] op, input int unsigned pos,
                         input logic [VALUE_W-1:0] val);
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, val, POS_W'(pos), op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if ($urandom_range(0, 39) == 0) quiet_tx = !quiet_tx;
  endtask

  // Hold the sender off until every reply owed has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (shadow.pending_replies.size() != 0);
  endtask

  task automatic random_op(input int mix);
    int unsigned         roll;
    int unsigned         fill;
    int unsigned         ins_pct;
    int unsigned         del_pct;
    int unsigned         pos;
    int unsigned         span;
    logic [OPCODE_W-1:0] op;
    fill = shadow.n_entries;
    case (mix)
      MIX_GROW: begin
        ins_pct = 90;
        del_pct = 2;
      end
      MIX_SHRINK: begin
        ins_pct = 8;
        del_pct = 80;
      end
      default: begin
        ins_pct = 45;
        del_pct = 30;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < NOISE_PCT) begin
      // Unused opcode, or a position at or past the end.
      if ($urandom_range(0, 1) == 1) begin
        op = OPCODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_READ;
          1:       op = OP_INSERT;
          default: op = OP_DELETE;
        endcase
      end
      pos = $urandom_range(fill, POS_MAX);
    end else if (roll < NOISE_PCT + ins_pct) begin
      case ($urandom_range(0, 2))
        0:       op = OP_INSERT;
        1:       op = OP_HEAD;
        default: op = OP_TAIL;
      endcase
      pos = (op == OP_INSERT) ? $urandom_range(0, fill) : $urandom_range(0, POS_MAX);
    end else if (roll < NOISE_PCT + ins_pct + del_pct) begin
      op  = OP_DELETE;
      pos = (fill == 0) ? 0 : $urandom_range(0, fill - 1);
    end else begin
      // Reads walk the row, so keep most of them near the head.
      op = OP_READ;
      if (fill == 0) begin
        pos = 0;
      end else if ($urandom_range(0, 99) < 8) begin
        span = (fill - 1 < 15) ? fill - 1 : 15;
        pos  = $urandom_range(fill - 1 - span, fill - 1);
      end else begin
        pos = $urandom_range(0, (fill - 1 < 31) ? fill - 1 : 31);
      end
    end
    send_op(op, pos, VALUE_W'($urandom_range(0, VALUE_MAX)));
  endtask

  initial begin
    int unsigned k;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty store: every read and delete is out of range, as is an insert past the end.
    send_op(OP_READ, 0, 16'h0000);
    send_op(OP_DELETE, 0, 16'h0000);
    send_op(OP_INSERT, 1, 16'h0001);
    send_op(OP_INSERT, 0, 16'hFFFF);
    send_op(OP_HEAD, 0, 16'h0000);
    send_op(OP_TAIL, 0, 16'hA5A5);
    send_op(OP_INSERT, 3, 16'h5A5A);
    send_op(OP_INSERT, 2, 16'h1234);
    send_op(OP_READ, 0, 16'hFFFF);
    send_op(OP_READ, 4, 16'h0000);
    send_op(OP_READ, 2, 16'h0000);
    send_op(OP_READ, 5, 16'h0000);
    send_op(OP_READ, POS_MAX, 16'hFFFF);
    send_op(OP_DELETE, POS_MAX, 16'hFFFF);
    send_op(OP_INSERT, POS_MAX, 16'hFFFF);
    for (k = 32'(OP_UNUSED_FIRST); k <= 32'(OP_UNUSED_LAST); k++) begin
      send_op(OPCODE_W'(k), 0, 16'hFFFF);
    end
    send_op(OP_DELETE, 4, 16'h0000);
    send_op(OP_DELETE, 0, 16'h0000);
    send_op(OP_DELETE, 1, 16'h0000);
    send_op(OP_READ, 1, 16'h0000);
    send_op(OP_READ, 0, 16'h0000);
    send_op(OP_HEAD, POS_MAX, 16'h8001);
    drain();

    for (k = 0; k < 300; k++) random_op(MIX_EVEN);
    drain();

    while (shadow.n_entries < CAPACITY) random_op(MIX_GROW);

    // Full store: the range check on insert wins over the full check.
    send_op(OP_INSERT, CAPACITY + 1, 16'hFFFF);
    send_op(OP_INSERT, CAPACITY, 16'h0F0F);
    send_op(OP_HEAD, 0, 16'hF0F0);
    send_op(OP_TAIL, 0, 16'h1111);
    send_op(OP_READ, CAPACITY - 1, 16'h0000);
    send_op(OP_DELETE, CAPACITY, 16'h0000);
    send_op(OP_READ, POS_MAX, 16'h0000);
    for (k = 0; k < 30; k++) random_op(MIX_GROW);

    for (k = 0; k < 370; k++) random_op(MIX_SHRINK);

    s_axis_tvalid <= 1'b0;
    while (shadow.pending_replies.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d operations and checked %0d replies in %0d cycles.",
             shadow.n_ops, shadow.n_replies, cycle_cnt);
    $display("Rejected %0d as full and %0d as out of range; peak fill %0d of %0d.",
             shadow.n_full, shadow.n_range, shadow.peak, CAPACITY);
    if (shadow.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
